// ===== src/wmms_pkg.sv =====
// Shared types and constants for the windowed min/max stability unit.
// No dependencies; imported by wmms_ring and the top level.
`timescale 1ns / 1ps

package wmms_pkg;

    localparam int DATA_W = 15;
    localparam int TIME_W = 32;

    localparam int SHORT_LEN_DEF = 120;
    localparam int LONG_LEN_DEF  = 300;

    localparam logic signed [DATA_W-1:0] BAND_LOW_RST  = 15'sd4100;
    localparam logic signed [DATA_W-1:0] BAND_HIGH_RST = 15'sd4500;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 1'b1;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 96;

    typedef logic signed [DATA_W-1:0] t_sample;

    // per-cycle commands from the sequencer to each ring
    typedef struct packed {
        logic mod_step;  // advance the slot remainder pipeline
        logic clr_wr;    // write zero at sweep index
        logic item_wr;   // write sample at computed slot
        logic rd;        // read at sweep index
        logic first;     // this read opens a new scan
    } t_ring_ctl;

endpackage

// ===== src/wmms_ring.sv =====
// One sample ring: storage, pipelined slot remainder and min/max scan tracker.
// Depends on wmms_pkg.
`timescale 1ns / 1ps

module wmms_ring #(
    parameter int LEN   = wmms_pkg::SHORT_LEN_DEF,
    parameter int IDX_W = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wmms_pkg::t_ring_ctl         i_ctl,
    input  logic [wmms_pkg::TIME_W-1:0] i_now,
    input  logic [IDX_W-1:0]            i_idx,
    input  wmms_pkg::t_sample           i_wdata,
    output wmms_pkg::t_sample           o_min,
    output wmms_pkg::t_sample           o_max
);
    import wmms_pkg::*;

    localparam int AW = $clog2(LEN);
    localparam int RW = AW + 1;
    localparam logic [RW-1:0] LEN_R = RW'(LEN);
    localparam logic [TIME_W-1:0] LEN_T = TIME_W'(LEN);
    // floor(2^32 / LEN); the estimated quotient is at most one short
    localparam logic [TIME_W-1:0] RECIP = TIME_W'(64'h1_0000_0000 / 64'(LEN));

    t_sample r_mem [LEN];
    t_sample r_rdata;
    t_sample r_min;
    t_sample r_max;
    logic    r_rd_vld;
    logic    r_rd_first;
    logic [TIME_W-1:0]   r_quo;
    logic [RW-1:0]       r_part;
    logic [AW-1:0]       r_rem;
    logic [2*TIME_W-1:0] w_prod;
    logic [TIME_W-1:0]   w_back;
    logic                w_in_range;
    logic [AW-1:0]       w_idx_addr;

    assign w_in_range = (32'(i_idx) < 32'(LEN));
    assign w_idx_addr = AW'(i_idx);

    // slot = now mod LEN: reciprocal multiply, back-multiply and subtract
    // (leaves 0..2*LEN-1), then one conditional subtract; i_now is held
    assign w_prod = {{TIME_W{1'b0}}, i_now} * {{TIME_W{1'b0}}, RECIP};
    assign w_back = r_quo * LEN_T;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mod_step) begin
            r_quo  <= w_prod[2*TIME_W-1:TIME_W];
            r_part <= RW'(i_now - w_back);
            r_rem  <= (r_part >= LEN_R) ? AW'(r_part - LEN_R) : AW'(r_part);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_wr && w_in_range) begin
            r_mem[w_idx_addr] <= '0;
        end else if (i_ctl.item_wr) begin
            r_mem[r_rem] <= i_wdata;
        end
        if (i_ctl.rd && w_in_range) begin
            r_rdata <= r_mem[w_idx_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
        end else begin
            r_rd_vld   <= i_ctl.rd && w_in_range;
            r_rd_first <= i_ctl.first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_rd_first) begin
                r_min <= r_rdata;
                r_max <= r_rdata;
            end else begin
                if (r_rdata < r_min) r_min <= r_rdata;
                if (r_rdata > r_max) r_max <= r_rdata;
            end
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

// ===== src/windowed_min_max_stability_unit.sv =====
// Top level of the windowed min/max stability unit: sequencer, band test,
// stable mark and output register. Depends on wmms_pkg and wmms_ring.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_axis): one temperature sample and a time stamp in
//   seconds per transaction. Output stream (m_axis): one result per sample
//   with the short and long ring extremes and the seconds since a sample
//   last lay outside the stability band. Band edges come in over the config
//   write port (index 0 band_low, index 1 band_high); the user writes them
//   only while the unit is idle, and the block itself does not enforce it.
//   Per sample: the slot remainders are computed (reciprocal multiply,
//   back-multiply and subtract, final correction), the sample is written,
//   then both rings are scanned together at one entry per cycle through
//   the single read port of each memory over MAX_LEN entries, where MAX_LEN
//   is the larger ring length (300 at the defaults); the last read is
//   folded into the extremes, then the output register is loaded. One
//   sample is in flight at a time; the next is accepted after that load.
//   Reset: after i_rst_n is released, a clearing pass zeroes both rings,
//   one entry per cycle over MAX_LEN entries; s_axis_tready stays low until
//   it ends. Config writes are taken during the pass.
//   Stall: the result sits in an output register; the next sample is
//   accepted and processed meanwhile, and only the final load waits until
//   the pending result is taken.
module windowed_min_max_stability_unit #(
    parameter int SHORT_LEN = wmms_pkg::SHORT_LEN_DEF,
    parameter int LONG_LEN  = wmms_pkg::LONG_LEN_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [14:0] temperature, [46:15] now_seconds, [47] zero
    input  logic [wmms_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [14:0] short_min, [29:15] short_max, [44:30] long_min,
    // [59:45] long_max, [91:60] stable_seconds, [95:92] zero
    output logic [wmms_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [wmms_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wmms_pkg::DATA_W-1:0]          i_cfg_wdata
);
    import wmms_pkg::*;

    localparam int MAX_LEN = (SHORT_LEN > LONG_LEN) ? SHORT_LEN : LONG_LEN;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LEN - 1);
    // depth of the slot remainder pipeline in each ring
    localparam int MOD_STEPS = 3;
    localparam logic [1:0] MOD_LAST = 2'(MOD_STEPS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_WRITE,
        S_SCAN,
        S_TAIL,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_idx;
    logic [1:0]          r_step;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_mark;
    logic [TIME_W-1:0]   r_stable;
    t_sample             r_temp;
    t_sample             r_band_low;
    t_sample             r_band_high;
    logic                r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;

    t_ring_ctl           w_ctl;
    t_sample             w_s_min, w_s_max, w_l_min, w_l_max;
    t_sample             w_in_temp;
    logic [TIME_W-1:0]   w_in_now;
    logic [TIME_W-1:0]   n_mark;
    logic                w_accept;
    logic                w_outside;
    logic                w_load;

    assign w_in_temp = t_sample'(s_axis_tdata[DATA_W-1:0]);
    assign w_in_now  = s_axis_tdata[DATA_W +: TIME_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_outside = (w_in_temp < r_band_low) || (w_in_temp > r_band_high);
    assign n_mark    = w_outside ? w_in_now : r_mark;
    assign w_load    = (r_state == S_DONE) && (!r_out_vld || m_axis_tready);

    always_comb begin
        w_ctl          = '0;
        w_ctl.mod_step = (r_state == S_MOD);
        w_ctl.clr_wr   = (r_state == S_CLEAR);
        w_ctl.item_wr  = (r_state == S_WRITE);
        w_ctl.rd       = (r_state == S_SCAN);
        w_ctl.first    = (r_state == S_SCAN) && (r_idx == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_step      <= '0;
            r_mark      <= '0;
            r_band_low  <= BAND_LOW_RST;
            r_band_high <= BAND_HIGH_RST;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BAND_LOW:  r_band_low  <= t_sample'(i_cfg_wdata);
                    CFG_BAND_HIGH: r_band_high <= t_sample'(i_cfg_wdata);
                    default: ;
                endcase
            end

            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_idx == IDX_LAST) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_temp   <= w_in_temp;
                        r_now    <= w_in_now;
                        r_mark   <= n_mark;
                        r_stable <= w_in_now - n_mark;
                        r_step   <= '0;
                        r_state  <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == MOD_LAST) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_idx   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_idx == IDX_LAST) begin
                        r_idx   <= '0;
                        r_state <= S_TAIL;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TAIL: begin
                    // last read data is folded into the extremes here
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_out_data <= {4'b0, r_stable, w_l_max, w_l_min,
                                       w_s_max, w_s_min};
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    wmms_ring #(
        .LEN   (SHORT_LEN),
        .IDX_W (IDX_W)
    ) u_short_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_now   (r_now),
        .i_idx   (r_idx),
        .i_wdata (r_temp),
        .o_min   (w_s_min),
        .o_max   (w_s_max)
    );

    wmms_ring #(
        .LEN   (LONG_LEN),
        .IDX_W (IDX_W)
    ) u_long_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_now   (r_now),
        .i_idx   (r_idx),
        .i_wdata (r_temp),
        .o_min   (w_l_min),
        .o_max   (w_l_max)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule
